### src/raster_row_packbits_framer_unit_assert.svh
// ---------------------------------------------------------------------------
// raster row packbits framer: assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ---------------------------------------------------------------------------
`ifndef RASTER_ROW_PACKBITS_FRAMER_UNIT_ASSERT_SVH
`define RASTER_ROW_PACKBITS_FRAMER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// checked on clk, quiet while rst_n is low
`define RRPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on clk, also while rst_n is low
`define RRPF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRPF_ASSERT(lbl, prop, msg)
`define RRPF_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### src/rrpf_pkg.sv
// ---------------------------------------------------------------------------
// rrpf_pkg
// shared constants and types of the raster row packbits framer
// ---------------------------------------------------------------------------
package rrpf_pkg;

    localparam int ROW_BYTES  = 16;
    localparam int HALF_BYTES = ROW_BYTES / 2;
    localparam int HALF_W     = HALF_BYTES * 8;
    localparam int IDX_W      = $clog2(ROW_BYTES);
    localparam int POS_W      = IDX_W + 1;
    // payload of one row never exceeds 24 bytes
    localparam int PAY_W      = 5;

    localparam logic [7:0] FRAME_TAG = 8'h47;
    localparam logic [7:0] EMPTY_TAG = 8'h5A;
    localparam logic [7:0] LEN_HI    = 8'h00;
    localparam logic [7:0] RAW_LEN   = 8'(ROW_BYTES);

    localparam logic [POS_W-1:0] ROW_END  = POS_W'(ROW_BYTES);
    localparam logic [POS_W-1:0] MIN_RUN  = POS_W'(3);
    localparam logic [PAY_W-1:0] RUN_COST = PAY_W'(2);

    // segment found by one lane: kind and end position (exclusive)
    typedef struct packed {
        logic             is_run;
        logic [POS_W-1:0] seg_end;
    } seg_t;

    // segment currently addressed by the walker
    typedef struct packed {
        logic             is_run;
        logic [POS_W-1:0] seg_start;
        logic [POS_W-1:0] seg_end;
    } cur_seg_t;

    typedef struct packed {
        logic load;
        logic advance;
    } walk_ctl_t;

    typedef struct packed {
        logic             len_done;
        logic [PAY_W-1:0] payload_len;
    } walk_stat_t;

endpackage

### src/rrpf_row_if.sv
// ---------------------------------------------------------------------------
// rrpf_row_if
// row channel: one 16-byte raster row per word, valid/ready handshake
// ---------------------------------------------------------------------------
interface rrpf_row_if;

    logic                        valid;
    logic                        ready;
    logic [rrpf_pkg::HALF_W-1:0] row_first_half;
    logic [rrpf_pkg::HALF_W-1:0] row_second_half;

    modport source (output valid, output row_first_half, output row_second_half,
                    input ready);
    modport sink   (input valid, input row_first_half, input row_second_half,
                    output ready);

endinterface

### src/rrpf_byte_if.sv
// ---------------------------------------------------------------------------
// rrpf_byte_if
// byte channel: one framed byte per word, valid/ready handshake
// ---------------------------------------------------------------------------
interface rrpf_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_row;

    modport source (output valid, output out_byte, output last_of_row, input ready);
    modport sink   (input valid, input out_byte, input last_of_row, output ready);

endinterface

### src/rrpf_lane.sv
// ---------------------------------------------------------------------------
// rrpf_lane
// segment finder for one row position: run length and literal stretch end
// ---------------------------------------------------------------------------
module rrpf_lane (
    input  logic [rrpf_pkg::IDX_W-1:0]     lane_idx,
    input  logic [rrpf_pkg::ROW_BYTES-1:0] eq,
    output rrpf_pkg::seg_t                 seg
);

    logic [rrpf_pkg::POS_W-1:0] run_end;
    logic [rrpf_pkg::POS_W-1:0] lit_end;
    logic [rrpf_pkg::POS_W-1:0] run_len;

    // first break in the chain of equal neighbours after this position
    always_comb
    begin
        run_end = rrpf_pkg::ROW_END;
        for (int p = rrpf_pkg::ROW_BYTES - 1; p >= 1; p--)
        begin
            if ((rrpf_pkg::POS_W'(p) > {1'b0, lane_idx}) && !eq[p-1])
            begin
                run_end = rrpf_pkg::POS_W'(p);
            end
        end
    end

    // literal stops before the next equal pair at or after the run end
    always_comb
    begin
        lit_end = rrpf_pkg::ROW_END;
        for (int p = rrpf_pkg::ROW_BYTES - 1; p >= 0; p--)
        begin
            if ((rrpf_pkg::POS_W'(p) >= run_end) && eq[p])
            begin
                lit_end = rrpf_pkg::POS_W'(p);
            end
        end
    end

    assign run_len     = run_end - {1'b0, lane_idx};
    assign seg.is_run  = (run_len >= rrpf_pkg::MIN_RUN);
    assign seg.seg_end = seg.is_run ? run_end : lit_end;

endmodule

### src/rrpf_walk.sv
// ---------------------------------------------------------------------------
// rrpf_walk
// merge stage: holds the lane results, sums the payload length segment by
// segment, then steps through the segments for the byte emitter
// ---------------------------------------------------------------------------
`include "raster_row_packbits_framer_unit_assert.svh"

module rrpf_walk (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rrpf_pkg::walk_ctl_t  ctl,
    input  rrpf_pkg::seg_t       lane_seg [rrpf_pkg::ROW_BYTES],
    output rrpf_pkg::walk_stat_t stat,
    output rrpf_pkg::cur_seg_t   cur
);

    typedef enum logic {
        P_SUM,
        P_SERVE
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [rrpf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [rrpf_pkg::PAY_W-1:0] acc_reg, acc_next;
    logic                       done_reg, done_next;

    rrpf_pkg::seg_t             seg_reg [rrpf_pkg::ROW_BYTES];
    rrpf_pkg::seg_t             rd_seg;
    logic [rrpf_pkg::POS_W-1:0] rd_len;
    logic [rrpf_pkg::PAY_W-1:0] cost;

    assign rd_seg = seg_reg[pos_reg[rrpf_pkg::IDX_W-1:0]];
    assign rd_len = rd_seg.seg_end - pos_reg;
    assign cost   = rd_seg.is_run ? rrpf_pkg::RUN_COST
                                  : rrpf_pkg::PAY_W'(rd_len) + rrpf_pkg::PAY_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        if (ctl.load)
        begin
            phase_next = P_SUM;
            pos_next   = '0;
            acc_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                P_SUM:
                begin
                    acc_next = acc_reg + cost;
                    if (rd_seg.seg_end == rrpf_pkg::ROW_END)
                    begin
                        phase_next = P_SERVE;
                        pos_next   = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        pos_next = rd_seg.seg_end;
                    end
                end
                P_SERVE:
                begin
                    if (ctl.advance)
                    begin
                        pos_next = rd_seg.seg_end;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_SERVE;
            pos_reg   <= '0;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            done_reg  <= done_next;
        end
    end

    // segment table, taken from the lanes in one go
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int i = 0; i < rrpf_pkg::ROW_BYTES; i++)
            begin
                seg_reg[i] <= lane_seg[i];
            end
        end
    end

    assign stat.len_done    = done_reg;
    assign stat.payload_len = acc_reg;
    assign cur.is_run       = rd_seg.is_run;
    assign cur.seg_start    = pos_reg;
    assign cur.seg_end      = rd_seg.seg_end;

    `RRPF_ASSERT(a_sum_inside_row, phase_reg == P_SUM |-> pos_reg < rrpf_pkg::ROW_END, "sum walk left the row")
    `RRPF_ASSERT(a_done_rewinds, done_reg |-> phase_reg == P_SERVE && pos_reg == '0, "length done without rewind")
    `RRPF_ASSERT(a_sum_moves_on, phase_reg == P_SUM && !ctl.load |=> phase_reg == P_SERVE || pos_reg > $past(pos_reg), "sum walk stalled")

endmodule

### src/raster_row_packbits_framer_unit.sv
// ---------------------------------------------------------------------------
// raster_row_packbits_framer_unit
// takes one 16-byte raster row and emits its framed byte stream, packbits
// or raw, through a registered output stage: one byte per cycle from the tag
//   on while the sink stays ready; in packbits mode the payload length is
//   summed segment by segment before the tag, raw rows skip that sum
// rows: one at a time; a new row is accepted only in idle, after the last
//   byte of the previous row has been loaded into the output stage
// reset: asynchronous, active low; idle, output empty, compress_enable = 1
// ---------------------------------------------------------------------------
`include "raster_row_packbits_framer_unit_assert.svh"

module raster_row_packbits_framer_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic         wr_data,
    rrpf_row_if.sink     row_ch,
    rrpf_byte_if.source  byte_ch
);

    // row sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_EMPTY,
        S_WALK,
        S_TAG,
        S_LEN_LO,
        S_LEN_HI,
        S_SEG_HDR,
        S_DATA
    } state_t;

    state_t                     state_reg, state_next;
    logic                       compress_enable_reg, compress_enable_next;
    logic                       mode_reg, mode_next;
    logic [rrpf_pkg::POS_W-1:0] ptr_reg, ptr_next;
    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_byte_reg, out_byte_next;
    logic                       out_last_reg, out_last_next;

    // row bytes, byte 0 first
    logic [7:0]                 row_reg [rrpf_pkg::ROW_BYTES];
    logic [7:0]                 row_rd;
    logic                       row_take;
    logic                       row_zero;
    logic [rrpf_pkg::ROW_BYTES-1:0] eq;

    rrpf_pkg::seg_t             lane_seg [rrpf_pkg::ROW_BYTES];
    rrpf_pkg::walk_ctl_t        wctl;
    rrpf_pkg::walk_stat_t       wstat;
    rrpf_pkg::cur_seg_t         cur;

    logic                       can_load;
    logic                       emit;
    logic [7:0]                 emit_byte;
    logic                       emit_last;
    logic [rrpf_pkg::POS_W-1:0] ptr_inc;

    // packbits segment header: 1-n for a run, n-1 for a literal stretch
    function automatic logic [7:0] seg_hdr(input rrpf_pkg::cur_seg_t s);
        logic [7:0] n;
        n = 8'(s.seg_end - s.seg_start);
        return s.is_run ? (8'd1 - n) : (n - 8'd1);
    endfunction

    assign row_take = row_ch.valid && row_ch.ready;
    assign row_ch.ready = (state_reg == S_IDLE);

    // output slot free now or freed by the sink this cycle
    assign can_load = !out_valid_reg || byte_ch.ready;

    assign row_rd  = row_reg[ptr_reg[rrpf_pkg::IDX_W-1:0]];
    assign ptr_inc = ptr_reg + rrpf_pkg::POS_W'(1);

    // neighbour compare lanes; the place past the row never matches
    always_comb
    begin
        for (int i = 0; i < rrpf_pkg::ROW_BYTES - 1; i++)
        begin
            eq[i] = (row_reg[i] == row_reg[i+1]);
        end
        eq[rrpf_pkg::ROW_BYTES-1] = 1'b0;
    end

    always_comb
    begin
        row_zero = 1'b1;
        for (int i = 0; i < rrpf_pkg::ROW_BYTES; i++)
        begin
            if (row_reg[i] != 8'h00)
            begin
                row_zero = 1'b0;
            end
        end
    end

    // one segment finder per row position
    for (genvar g = 0; g < rrpf_pkg::ROW_BYTES; g++)
    begin : g_lane
        rrpf_lane u_lane (
            .lane_idx (rrpf_pkg::IDX_W'(g)),
            .eq       (eq),
            .seg      (lane_seg[g])
        );
    end

    // merge stage: length sum, then segment stepping
    rrpf_walk u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (wctl),
        .lane_seg (lane_seg),
        .stat     (wstat),
        .cur      (cur)
    );

    always_comb
    begin
        state_next           = state_reg;
        mode_next            = mode_reg;
        ptr_next             = ptr_reg;
        compress_enable_next = wr_en ? wr_data : compress_enable_reg;
        wctl                 = '0;
        emit                 = 1'b0;
        emit_byte            = rrpf_pkg::FRAME_TAG;
        emit_last            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (row_take)
                begin
                    mode_next  = compress_enable_reg;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // raw rows skip the length sum, blank packed rows get one tag
                if (!mode_reg)
                begin
                    state_next = S_TAG;
                end
                else if (row_zero)
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    wctl.load  = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_EMPTY:
            begin
                if (can_load)
                begin
                    emit       = 1'b1;
                    emit_byte  = rrpf_pkg::EMPTY_TAG;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (wstat.len_done)
                begin
                    state_next = S_TAG;
                end
            end
            S_TAG:
            begin
                if (can_load)
                begin
                    emit       = 1'b1;
                    emit_byte  = rrpf_pkg::FRAME_TAG;
                    state_next = S_LEN_LO;
                end
            end
            S_LEN_LO:
            begin
                if (can_load)
                begin
                    emit       = 1'b1;
                    emit_byte  = mode_reg ? 8'(wstat.payload_len) : rrpf_pkg::RAW_LEN;
                    state_next = S_LEN_HI;
                end
            end
            S_LEN_HI:
            begin
                if (can_load)
                begin
                    emit       = 1'b1;
                    emit_byte  = rrpf_pkg::LEN_HI;
                    ptr_next   = '0;
                    state_next = mode_reg ? S_SEG_HDR : S_DATA;
                end
            end
            S_SEG_HDR:
            begin
                if (can_load)
                begin
                    emit       = 1'b1;
                    emit_byte  = seg_hdr(cur);
                    ptr_next   = cur.seg_start;
                    state_next = S_DATA;
                end
            end
            S_DATA:
            begin
                if (can_load)
                begin
                    emit      = 1'b1;
                    emit_byte = row_rd;
                    if (!mode_reg)
                    begin
                        // raw body: all row bytes in order
                        ptr_next  = ptr_inc;
                        emit_last = (ptr_inc == rrpf_pkg::ROW_END);
                        if (emit_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else if (cur.is_run)
                    begin
                        // run: value byte once
                        wctl.advance = 1'b1;
                        emit_last    = (cur.seg_end == rrpf_pkg::ROW_END);
                        state_next   = emit_last ? S_IDLE : S_SEG_HDR;
                    end
                    else
                    begin
                        // literal: each byte up to the segment end
                        ptr_next = ptr_inc;
                        if (ptr_inc == cur.seg_end)
                        begin
                            wctl.advance = 1'b1;
                            emit_last    = (cur.seg_end == rrpf_pkg::ROW_END);
                            state_next   = emit_last ? S_IDLE : S_SEG_HDR;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // output register: hold until taken, reload when a word goes out
        out_valid_next = out_valid_reg && !byte_ch.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            compress_enable_reg <= 1'b1;
            mode_reg            <= 1'b1;
            ptr_reg             <= '0;
            out_valid_reg       <= 1'b0;
            out_byte_reg        <= '0;
            out_last_reg        <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            compress_enable_reg <= compress_enable_next;
            mode_reg            <= mode_next;
            ptr_reg             <= ptr_next;
            out_valid_reg       <= out_valid_next;
            out_byte_reg        <= out_byte_next;
            out_last_reg        <= out_last_next;
        end
    end

    // row capture, byte 0 from the top of the first half
    always_ff @(posedge clk)
    begin
        if (row_take)
        begin
            for (int i = 0; i < rrpf_pkg::HALF_BYTES; i++)
            begin
                row_reg[i] <=
                    row_ch.row_first_half[(rrpf_pkg::HALF_BYTES - 1 - i) * 8 +: 8];
                row_reg[rrpf_pkg::HALF_BYTES + i] <=
                    row_ch.row_second_half[(rrpf_pkg::HALF_BYTES - 1 - i) * 8 +: 8];
            end
        end
    end

    assign byte_ch.valid       = out_valid_reg;
    assign byte_ch.out_byte    = out_byte_reg;
    assign byte_ch.last_of_row = out_last_reg;

    `RRPF_ASSERT(a_accept_to_scan, row_take |=> state_reg == S_SCAN, "accepted row did not start a scan")
    `RRPF_ASSERT(a_last_to_idle, emit && emit_last |=> state_reg == S_IDLE && byte_ch.last_of_row, "last word did not close the row")
    `RRPF_ASSERT(a_data_in_row, state_reg == S_DATA |-> ptr_reg < rrpf_pkg::ROW_END, "data pointer past the row")
    `RRPF_ASSERT(a_literal_in_seg, state_reg == S_DATA && mode_reg && !cur.is_run |-> ptr_reg >= cur.seg_start && ptr_reg < cur.seg_end, "literal pointer outside its segment")
    `RRPF_ASSERT_RST(a_reset_quiet, !rst_n |-> !byte_ch.valid, "output valid during reset")

endmodule

### sim/raster_row_packbits_framer_unit_test.sv
// ---------------------------------------------------------------------------
// raster_row_packbits_framer_unit_test
// self-checking bench: rows go in over the row channel, every framed byte
// coming out is checked against a typed frame or a local packbits/raw framer, with random
// idling on both channels and mode changes between phases
// ---------------------------------------------------------------------------
module raster_row_packbits_framer_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    // longest run or literal stretch the bench framer forms, one full row
    localparam int RUN_MAX = 16;
    // cycles with no word moving on either channel before giving up
    localparam int STALL_LIMIT = 1000;
    // cycles left for stray bytes once the last expected byte is in
    localparam int SETTLE_CYCLES = 50;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    // one directed row: mode, row halves and, where obvious, its frame
    // (byte 0 of the frame sits in the top used byte of typed_bytes)
    typedef struct packed {
        logic            compress;
        logic [63:0]     first_half;
        logic [63:0]     second_half;
        logic [4:0]      typed_len;
        logic [19:0][7:0] typed_bytes;
    } row_case_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic wr_data;

    rrpf_row_if  row_ch ();
    rrpf_byte_if byte_ch ();

    raster_row_packbits_framer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .row_ch  (row_ch),
        .byte_ch (byte_ch)
    );

    // bench copy of compress_enable, reset value 1
    logic             compress_mode = 1'b1;
    // framed bytes still owed by the block, oldest first
    frame_byte_t      pending_bytes [$];
    int               mismatches = 0;
    int               quiet_cycles = 0;
    // idling knobs, in percent: sink stalls per cycle, source gaps per row
    int               rx_stall_pct = 0;
    int               tx_gap_pct = 0;
    int               rx_stall_left = 0;
    // typed frame travelling with the row word on the channel
    logic [4:0]       cur_typed_len = '0;
    logic [19:0][7:0] cur_typed = '0;

    row_case_t directed_rows [20] = '{
        // all-zero row collapses to the empty tag
        '{1'b1, 64'h0, 64'h0, 5'd1, 160'h5A},
        // one run over the whole row
        '{1'b1, {8{8'hFF}}, {8{8'hFF}}, 5'd5, 160'h47_02_00_F1_FF},
        // fifteen zeros then a lone byte at the row end
        '{1'b1, 64'h0, 64'h0000_0000_0000_0001, 5'd7, 160'h47_04_00_F2_00_00_01},
        // lone byte at the start, then a fifteen-byte run
        '{1'b1, 64'h8000_0000_0000_0000, 64'h0, 5'd7, 160'h47_04_00_00_80_F2_00},
        // all literal, one stretch of sixteen
        '{1'b1, 64'h0001_0203_0405_0607, 64'h0809_0A0B_0C0D_0E0F, 5'd0, 160'h0},
        // equal pair at the start is absorbed into a literal
        '{1'b1, 64'hAAAA_BBCC_DDEE_0102, 64'h0304_0506_0708_090A, 5'd0, 160'h0},
        // equal pair at the row end
        '{1'b1, 64'h0102_0304_0506_0708, 64'h1122_3344_5566_7777, 5'd0, 160'h0},
        // shortest run, three bytes
        '{1'b1, 64'h5555_5501_0203_0405, 64'h0607_0809_0A0B_0C0D, 5'd0, 160'h0},
        // literal stops in front of an equal pair
        '{1'b1, 64'h0102_0303_0304_0506, 64'h0708_090A_0B0C_0D0E, 5'd0, 160'h0},
        // alternating bytes, never a pair
        '{1'b1, {4{16'h55AA}}, {4{16'h55AA}}, 5'd0, 160'h0},
        // full run of the top bit alone
        '{1'b1, {8{8'h80}}, {8{8'h80}}, 5'd5, 160'h47_02_00_F1_80},
        // two runs of eight
        '{1'b1, {8{8'h7F}}, {8{8'h01}}, 5'd7, 160'h47_04_00_F9_7F_F9_01},
        // pairs only, all end up literal
        '{1'b1, 64'h1111_2222_1111_2222, 64'h1111_2222_1111_2222, 5'd0, 160'h0},
        // run of fourteen then a pair at the row end
        '{1'b1, 64'h0, 64'h0000_0000_0000_0101, 5'd0, 160'h0},
        // raw framing of the extremes and of two mixed rows
        '{1'b0, 64'h0, 64'h0, 5'd19, 160'({24'h47_10_00, 128'h0})},
        '{1'b0, {8{8'hFF}}, {8{8'hFF}}, 5'd19, 160'({24'h47_10_00, {16{8'hFF}}})},
        '{1'b0, 64'h0001_0203_0405_0607, 64'h0809_0A0B_0C0D_0E0F, 5'd0, 160'h0},
        '{1'b0, {8{8'hA5}}, {8{8'h5A}}, 5'd0, 160'h0},
        // back to packbits
        '{1'b1, 64'h0, 64'h0, 5'd1, 160'h5A},
        '{1'b1, 64'h0000_0000_0000_00FF, 64'hFF00_0000_0000_0000, 5'd0, 160'h0}
    };

    // -----------------------------------------------------------------------
    // framer: queues the bytes one row should give in the current mode
    // -----------------------------------------------------------------------
    function automatic void predict_frame(input logic [63:0] fh, input logic [63:0] sh,
                                          input logic packed_mode);
        logic [7:0] row [rrpf_pkg::ROW_BYTES];
        logic [7:0] frame [$];
        int         start;
        int         pos;
        int         n;
        bit         all_zero;
        all_zero = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            row[i]     = fh[63 - 8 * i -: 8];
            row[8 + i] = sh[63 - 8 * i -: 8];
        end
        foreach (row[i])
            if (row[i] != 8'h00)
                all_zero = 1'b0;
        if (!packed_mode)
        begin
            frame = '{rrpf_pkg::FRAME_TAG, rrpf_pkg::RAW_LEN, rrpf_pkg::LEN_HI};
            foreach (row[i])
                frame.push_back(row[i]);
        end
        else if (all_zero)
        begin
            frame = '{rrpf_pkg::EMPTY_TAG};
        end
        else
        begin
            // length byte filled in once the payload is known
            frame = '{rrpf_pkg::FRAME_TAG, 8'h00, rrpf_pkg::LEN_HI};
            start = 0;
            while (start < rrpf_pkg::ROW_BYTES)
            begin
                pos = start + 1;
                while (pos < rrpf_pkg::ROW_BYTES && (pos - start) < RUN_MAX &&
                       row[pos] == row[start])
                    pos++;
                n = pos - start;
                if (n > 2)
                begin
                    frame.push_back(8'(1 - n));
                    frame.push_back(row[start]);
                end
                else
                begin
                    // literal runs up to an equal pair; past the row end counts as unequal
                    while (pos < rrpf_pkg::ROW_BYTES && (pos - start) < RUN_MAX &&
                           (pos + 1 >= rrpf_pkg::ROW_BYTES || row[pos] != row[pos + 1]))
                        pos++;
                    n = pos - start;
                    frame.push_back(8'(n - 1));
                    for (int i = 0; i < n; i++)
                        frame.push_back(row[start + i]);
                end
                start = pos;
            end
            frame[1] = 8'(frame.size() - 3);
        end
        foreach (frame[i])
            pending_bytes.push_back('{frame[i], i == frame.size() - 1});
    endfunction

    // -----------------------------------------------------------------------
    // clock
    // -----------------------------------------------------------------------
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // -----------------------------------------------------------------------
    // byte sink: ready low during reset and in random bursts of stall cycles
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_stall_left != 0)
        begin
            rx_stall_left = rx_stall_left - 1;
            byte_ch.ready <= 1'b0;
        end
        else if (rst_n && rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct)
        begin
            rx_stall_left = $urandom_range(1, 10) - 1;
            byte_ch.ready <= 1'b0;
        end
        else
        begin
            byte_ch.ready <= rst_n;
        end
    end

    // -----------------------------------------------------------------------
    // monitor: book each accepted row, check each accepted byte, watchdog
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n)
        begin
            if (row_ch.valid && row_ch.ready)
            begin
                if (cur_typed_len != 0)
                begin
                    for (int i = int'(cur_typed_len) - 1; i >= 0; i--)
                        pending_bytes.push_back('{cur_typed[i], i == 0});
                end
                else
                begin
                    predict_frame(row_ch.row_first_half, row_ch.row_second_half,
                                  compress_mode);
                end
            end

            if (byte_ch.valid && byte_ch.ready)
            begin
                if (pending_bytes.size() == 0)
                begin
                    mismatches++;
                    $error("word with nothing expected: out_byte %h last_of_row %b",
                           byte_ch.out_byte, byte_ch.last_of_row);
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (byte_ch.out_byte !== want.value)
                    begin
                        mismatches++;
                        $error("out_byte: expected %h, got %h", want.value, byte_ch.out_byte);
                    end
                    if (byte_ch.last_of_row !== want.last)
                    begin
                        mismatches++;
                        $error("last_of_row: expected %b, got %b",
                               want.last, byte_ch.last_of_row);
                    end
                end
            end

            // watchdog on cycles where neither channel moves a word
            if ((row_ch.valid && row_ch.ready) || (byte_ch.valid && byte_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $error("no word moved for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // row source; called at a falling edge, returns at a falling edge
    // -----------------------------------------------------------------------
    task automatic send_row(input logic [63:0] fh, input logic [63:0] sh,
                            input logic [4:0] typed_len, input logic [19:0][7:0] typed);
        // optional gap in front of the word
        if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct)
        begin
            row_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        row_ch.valid           <= 1'b1;
        row_ch.row_first_half  <= fh;
        row_ch.row_second_half <= sh;
        cur_typed_len = typed_len;
        cur_typed     = typed;
        do
            @(posedge clk);
        while (!row_ch.ready);
        @(negedge clk);
    endtask

    // hold the row channel until every owed byte has come out
    task automatic wait_drained();
        row_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_bytes.size() != 0);
    endtask

    // mode change, only with the block idle
    task automatic write_mode(input logic mode);
        wait_drained();
        wr_en   <= 1'b1;
        wr_data <= mode;
        compress_mode = mode;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        logic [7:0]  rowb [rrpf_pkg::ROW_BYTES];
        logic [63:0] fh;
        logic [63:0] sh;
        logic [7:0]  seg_val;
        bit          seg_run;
        int          idx;
        int          seg_len;
        int          kind;
        // random phases: mode, length and idling level; the last has none
        logic        phase_mode  [5];
        int          phase_items [5];
        int          phase_stall [5];
        int          phase_gap   [5];

        phase_mode  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        phase_items = '{45, 25, 35, 15, 30};
        phase_stall = '{20, 40, 10, 50, 0};
        phase_gap   = '{20, 35, 10, 50, 0};

        rst_n                  = 1'b0;
        wr_en                  = 1'b0;
        wr_data                = 1'b0;
        row_ch.valid           = 1'b0;
        row_ch.row_first_half  = '0;
        row_ch.row_second_half = '0;
        byte_ch.ready          = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, light idling
        rx_stall_pct = 15;
        tx_gap_pct   = 15;
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].compress != compress_mode)
                write_mode(directed_rows[k].compress);
            send_row(directed_rows[k].first_half, directed_rows[k].second_half,
                     directed_rows[k].typed_len, directed_rows[k].typed_bytes);
        end

        // random rows, mostly built from runs and literal stretches
        foreach (phase_mode[p])
        begin
            write_mode(phase_mode[p]);
            rx_stall_pct = phase_stall[p];
            tx_gap_pct   = phase_gap[p];
            for (int n = 0; n < phase_items[p]; n++)
            begin
                // sender holds back once until the block has emptied
                if (p == 2 && n == phase_items[p] / 2)
                    wait_drained();
                kind = $urandom_range(9);
                if (kind == 0)
                begin
                    // plain noise
                    foreach (rowb[b])
                        rowb[b] = 8'($urandom);
                end
                else if (kind == 1)
                begin
                    // flat row, zero or not, sometimes with one odd byte
                    seg_val = $urandom_range(1) ? 8'h00 : 8'($urandom);
                    foreach (rowb[b])
                        rowb[b] = seg_val;
                    if ($urandom_range(1))
                        rowb[$urandom_range(rrpf_pkg::ROW_BYTES - 1)] = 8'($urandom);
                end
                else
                begin
                    // segments: runs of one value or literals seeded with repeats
                    idx = 0;
                    while (idx < rrpf_pkg::ROW_BYTES)
                    begin
                        seg_len = $urandom_range(1, ($urandom_range(3) == 0) ? RUN_MAX : 5);
                        seg_run = $urandom_range(1);
                        case ($urandom_range(3))
                            0:       seg_val = 8'h00;
                            1:       seg_val = 8'hFF;
                            default: seg_val = 8'($urandom);
                        endcase
                        for (int b = 0; b < seg_len && idx < rrpf_pkg::ROW_BYTES; b++)
                        begin
                            if (seg_run || $urandom_range(3) == 0)
                                rowb[idx] = seg_val;
                            else
                                rowb[idx] = 8'($urandom);
                            idx++;
                        end
                    end
                end
                for (int b = 0; b < 8; b++)
                begin
                    fh[63 - 8 * b -: 8] = rowb[b];
                    sh[63 - 8 * b -: 8] = rowb[8 + b];
                end
                send_row(fh, sh, 5'd0, '0);
            end
        end

        // let everything drain, then watch for stray bytes
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
